// ===== src/max_heap_priority_queue_assert.svh =====
// assertion macros for the max heap priority queue
// no dependencies; included by the modules that carry checks
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// implication property, disabled during reset
`define MHPQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// plain expression that holds on every clock out of reset
`define MHPQ_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`else
`define MHPQ_ASSERT(lbl, clk, rst, prop, msg)
`define MHPQ_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`endif
`endif

// ===== src/mhpq_pkg.sv =====
// shared types and constants for the max heap priority queue
// no dependencies
`default_nettype none
package mhpq_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SORT   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_INSERT     = 2'd1,
    CELL_SHIFT_UP   = 2'd2,
    CELL_SHIFT_DOWN = 2'd3
  } cell_op_t;

  // command broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t                   op;
    logic signed [DATA_W-1:0]   new_value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== src/max_heap_priority_queue.sv =====
// Priority queue of signed 32-bit values held as a descending sorted chain of 64 cells.
// Insert (operation 0) places a value; a full queue returns status 1 and keeps
// its contents. Delete (operation 1) returns the largest value, or zero with
// status 2 when empty. Sort (operation 2) drains all n held values in ascending order with
// tlast on the final beat and leaves the queue empty; it first shifts the entries to the
// bottom of the chain, then sends a beat per shift while the output is free. Every operation
// returns exactly one beat except sort, which returns n (or one empty beat); code 3 is taken
// and ignored. The chain shifts as a whole, so the sort length is set by the shift path
// through the cells. A new beat is taken only while the chain is idle and the output
// register is free or being emptied in the same cycle.
// depends on mhpq_pkg, mhpq_cell and max_heap_priority_queue_assert.svh
`default_nettype none
`include "max_heap_priority_queue_assert.svh"
module max_heap_priority_queue
  import mhpq_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // [1:0] operation, [33:2] value, rest zero
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] result_value, [33:32] status, rest zero
  output logic        m_axis_tlast    // last
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ALIGN = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t               state, state_next;
  logic [COUNT_W-1:0]   count, count_next;    // entries held
  logic [COUNT_W-1:0]   skip, skip_next;      // alignment shifts still to do
  logic [COUNT_W-1:0]   remain, remain_next;  // drain beats still to send

  // output register
  logic                 out_valid;
  logic [DATA_W-1:0]    out_value, out_value_next;
  status_t              out_status, out_status_next;
  logic                 out_last, out_last_next;
  logic                 load_out;

  cell_ctrl_t                ctrl;
  logic signed [DATA_W-1:0]  cell_value [CAPACITY];
  logic                      cell_take  [CAPACITY];
  logic                      cell_occ   [CAPACITY];

  logic                      in_fire, out_free;
  logic [1:0]                in_op;
  logic signed [DATA_W-1:0]  in_value;

  assign in_op    = s_axis_tdata[1:0];
  assign in_value = s_axis_tdata[2 +: DATA_W];
  assign out_free = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign in_fire  = s_axis_tvalid && s_axis_tready;

  // the chain: cell 0 holds the maximum, occupancy follows the count
  for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
    logic signed [DATA_W-1:0] up_val, dn_val;
    logic                     up_take;

    assign cell_occ[i] = COUNT_W'(i) < count;

    if (i == 0) begin : g_top
      assign up_val  = cell_value[i];
      assign up_take = 1'b0;
    end else begin : g_mid
      assign up_val  = cell_value[i-1];
      assign up_take = cell_take[i-1];
    end

    if (i == CAPACITY - 1) begin : g_bot
      assign dn_val = cell_value[i];
    end else begin : g_nbot
      assign dn_val = cell_value[i+1];
    end

    mhpq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (cell_occ[i]),
      .upper_value (up_val),
      .upper_take  (up_take),
      .lower_value (dn_val),
      .value       (cell_value[i]),
      .take        (cell_take[i])
    );
  end

  // sequencing of the chain and the output beat
  always_comb begin
    state_next      = state;
    count_next      = count;
    skip_next       = skip;
    remain_next     = remain;
    load_out        = 1'b0;
    out_value_next  = '0;
    out_status_next = STATUS_OK;
    out_last_next   = 1'b1;
    ctrl.op         = CELL_HOLD;
    ctrl.new_value  = in_value;

    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            OP_INSERT: begin
              load_out = 1'b1;
              if (count == COUNT_W'(CAPACITY)) begin
                out_status_next = STATUS_FULL;
              end else begin
                ctrl.op    = CELL_INSERT;
                count_next = count + COUNT_W'(1);
              end
            end
            OP_DELETE: begin
              load_out = 1'b1;
              if (count == '0) begin
                out_status_next = STATUS_EMPTY;
              end else begin
                out_value_next = cell_value[0];
                ctrl.op        = CELL_SHIFT_UP;
                count_next     = count - COUNT_W'(1);
              end
            end
            OP_SORT: begin
              if (count == '0) begin
                load_out        = 1'b1;
                out_status_next = STATUS_EMPTY;
              end else begin
                remain_next = count;
                skip_next   = COUNT_W'(CAPACITY) - count;
                state_next  = (count == COUNT_W'(CAPACITY)) ? ST_DRAIN : ST_ALIGN;
              end
            end
            default: ;  // unused code: no beat, no change
          endcase
        end
      end
      ST_ALIGN: begin
        // push held entries down so the minimum sits in the bottom cell
        ctrl.op   = CELL_SHIFT_DOWN;
        skip_next = skip - COUNT_W'(1);
        if (skip == COUNT_W'(1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          load_out       = 1'b1;
          out_value_next = cell_value[CAPACITY-1];
          out_last_next  = (remain == COUNT_W'(1));
          ctrl.op        = CELL_SHIFT_DOWN;
          remain_next    = remain - COUNT_W'(1);
          if (remain == COUNT_W'(1)) begin
            count_next = '0;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      skip      <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      skip   <= skip_next;
      remain <= remain_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value  <= out_value_next;
      out_status <= out_status_next;
      out_last   <= out_last_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_status, out_value};
  assign m_axis_tlast  = out_last;

  `MHPQ_ASSERT_ALWAYS(a_count_range, clk, rst, count <= COUNT_W'(CAPACITY), "count above capacity")
  `MHPQ_ASSERT(a_ready_idle, clk, rst, s_axis_tready |-> state == ST_IDLE, "ready while busy")
  `MHPQ_ASSERT(a_drain_nonzero, clk, rst, state == ST_DRAIN |-> remain != '0, "drain with nothing left")
  `MHPQ_ASSERT(a_insert_grow, clk, rst, in_fire && in_op == OP_INSERT && count != COUNT_W'(CAPACITY) |=> count == $past(count) + COUNT_W'(1), "insert did not grow count")
  `MHPQ_ASSERT(a_drain_order, clk, rst, state == ST_DRAIN && out_free && remain != COUNT_W'(1) |=> cell_value[CAPACITY-1] >= $past(cell_value[CAPACITY-1]), "drain not ascending")

endmodule
`default_nettype wire

// ===== src/mhpq_cell.sv =====
// one cell of the sorted chain: holds one entry, trades with its neighbors
// depends on mhpq_pkg
`default_nettype none
module mhpq_cell
  import mhpq_pkg::*;
(
  input  wire                      clk,
  input  cell_ctrl_t               ctrl,
  input  wire                      occupied,
  input  wire signed [DATA_W-1:0]  upper_value,
  input  wire                      upper_take,
  input  wire signed [DATA_W-1:0]  lower_value,
  output logic signed [DATA_W-1:0] value,
  output logic                     take
);

  logic signed [DATA_W-1:0] value_next;

  // new entry belongs here or above when this slot is empty or smaller
  assign take = !occupied || (ctrl.new_value > value);

  always_comb begin
    value_next = value;
    case (ctrl.op)
      CELL_INSERT: begin
        if (upper_take) begin
          value_next = upper_value;
        end else if (take) begin
          value_next = ctrl.new_value;
        end
      end
      CELL_SHIFT_UP:   value_next = lower_value;
      CELL_SHIFT_DOWN: value_next = upper_value;
      default:         value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
`default_nettype wire

// ===== tb/max_heap_priority_queue_test.sv =====
// self-checking bench for max_heap_priority_queue: directed rows then random op runs
// keeps its own binary heap to predict result beats (a directed row may type its result), scoreboard compared per field
// depends on mhpq_pkg and the max_heap_priority_queue rtl
module max_heap_priority_queue_test;
  import mhpq_pkg::*;

  // operation code that the block accepts and drops without a result
  localparam logic [1:0] OP_NOP = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int TAIL_CYCLES = 100;
  localparam int RUN_ITEMS   = 130;

  // one result beat as seen on the master side
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
    logic                     last;
  } beat_t;

  // directed row: when given is set the typed result replaces the heap prediction
  typedef struct packed {
    logic [1:0]               op;
    logic signed [DATA_W-1:0] value;
    logic                     given;
    logic signed [DATA_W-1:0] want_value;
    status_t                  want_status;
  } stim_row_t;

  localparam int N_ROWS = 21;
  localparam stim_row_t DIRECTED_ROWS [0:N_ROWS-1] = '{
    '{OP_DELETE, 32'sd0,          1'b1, 32'sd0,          STATUS_EMPTY},
    '{OP_SORT,   32'sd0,          1'b1, 32'sd0,          STATUS_EMPTY},
    '{OP_NOP,    -32'sd1,         1'b0, 32'sd0,          STATUS_OK},
    '{OP_INSERT, 32'sh7fffffff,   1'b1, 32'sd0,          STATUS_OK},
    '{OP_INSERT, 32'sh80000000,   1'b1, 32'sd0,          STATUS_OK},
    '{OP_INSERT, 32'sd0,          1'b1, 32'sd0,          STATUS_OK},
    '{OP_INSERT, -32'sd1,         1'b1, 32'sd0,          STATUS_OK},
    '{OP_INSERT, 32'sd5,          1'b1, 32'sd0,          STATUS_OK},
    '{OP_INSERT, 32'sd5,          1'b1, 32'sd0,          STATUS_OK},
    '{OP_INSERT, -32'sd5,         1'b1, 32'sd0,          STATUS_OK},
    '{OP_DELETE, 32'sd0,          1'b1, 32'sh7fffffff,   STATUS_OK},
    '{OP_DELETE, -32'sd1,         1'b1, 32'sd5,          STATUS_OK},
    '{OP_SORT,   32'sd0,          1'b0, 32'sd0,          STATUS_OK},
    '{OP_DELETE, 32'sd0,          1'b1, 32'sd0,          STATUS_EMPTY},
    '{OP_INSERT, 32'sh55555555,   1'b1, 32'sd0,          STATUS_OK},
    '{OP_INSERT, 32'shaaaaaaaa,   1'b1, 32'sd0,          STATUS_OK},
    '{OP_SORT,   32'sh7fffffff,   1'b0, 32'sd0,          STATUS_OK},
    '{OP_INSERT, 32'sd42,         1'b1, 32'sd0,          STATUS_OK},
    '{OP_SORT,   32'sd0,          1'b0, 32'sd0,          STATUS_OK},
    '{OP_NOP,    32'sd0,          1'b0, 32'sd0,          STATUS_OK},
    '{OP_DELETE, 32'sd0,          1'b1, 32'sd0,          STATUS_EMPTY}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // [1:0] operation, [33:2] value, rest zero
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // [31:0] result_value, [33:32] status, rest zero
  logic        m_axis_tlast;        // last

  max_heap_priority_queue u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // shadow heap, 1-indexed
  logic signed [DATA_W-1:0] heap_mem [1:CAPACITY];
  int                       held;
  beat_t                    pending_beats [$];

  // idle percentages per side, changed between runs
  int send_idle_pct;
  int recv_idle_pct;

  int failures;
  int mismatches;
  int beats_checked;
  int stall_cycles;
  int n_insert, n_full, n_delete, n_empty, n_sort, n_drained, max_sort;

  beat_t seen_beat;
  beat_t want_beat;

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver backpressure, one decision per cycle
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic void swap_slots(int a, int b);
    logic signed [DATA_W-1:0] t;
    t           = heap_mem[a];
    heap_mem[a] = heap_mem[b];
    heap_mem[b] = t;
  endfunction

  // push a slot down toward the leaves, never swapping on a tie
  function automatic void sink_slot(int top, int bound);
    int i, c;
    i = top;
    while (2 * i <= bound) begin
      c = 2 * i;
      if (c + 1 <= bound && heap_mem[c + 1] > heap_mem[c]) c = c + 1;
      if (heap_mem[c] > heap_mem[i]) begin
        swap_slots(c, i);
        i = c;
      end else begin
        break;
      end
    end
  endfunction

  function automatic void raise_slot(int pos);
    int i;
    i = pos;
    while (i > 1 && heap_mem[i / 2] < heap_mem[i]) begin
      swap_slots(i / 2, i);
      i = i / 2;
    end
  endfunction

  function automatic beat_t make_beat(logic signed [DATA_W-1:0] v, status_t st, logic lst);
    beat_t b;
    b.value  = v;
    b.status = st;
    b.last   = lst;
    return b;
  endfunction

  // advance the shadow heap by one accepted beat; keep selects whether the
  // predicted results go to the scoreboard
  function automatic void predict_beat(logic [1:0] op, logic signed [DATA_W-1:0] v, bit keep);
    logic signed [DATA_W-1:0] top;
    int n;
    case (op)
      OP_INSERT: begin
        n_insert++;
        if (held >= CAPACITY) begin
          n_full++;
          if (keep) pending_beats.push_back(make_beat('0, STATUS_FULL, 1'b1));
        end else begin
          held++;
          heap_mem[held] = v;
          raise_slot(held);
          if (keep) pending_beats.push_back(make_beat('0, STATUS_OK, 1'b1));
        end
      end
      OP_DELETE: begin
        n_delete++;
        if (held == 0) begin
          n_empty++;
          if (keep) pending_beats.push_back(make_beat('0, STATUS_EMPTY, 1'b1));
        end else begin
          top         = heap_mem[1];
          heap_mem[1] = heap_mem[held];
          held--;
          sink_slot(1, held);
          if (keep) pending_beats.push_back(make_beat(top, STATUS_OK, 1'b1));
        end
      end
      OP_SORT: begin
        n_sort++;
        n = held;
        if (n == 0) begin
          n_empty++;
          if (keep) pending_beats.push_back(make_beat('0, STATUS_EMPTY, 1'b1));
        end else begin
          // heapify, then move the max to the end one slot at a time
          for (int i = n / 2; i >= 1; i--) sink_slot(i, n);
          for (int i = n; i >= 2; i--) begin
            swap_slots(1, i);
            sink_slot(1, i - 1);
          end
          for (int i = 1; i <= n; i++)
            if (keep) pending_beats.push_back(make_beat(heap_mem[i], STATUS_OK, i == n));
          n_drained += n;
          if (n > max_sort) max_sort = n;
          held = 0;
        end
      end
      default: ;  // unused code, no result and no state change
    endcase
  endfunction

  // offer one beat on the slave side, with random gaps ahead of it
  task automatic drive_beat(input logic [1:0] op, input logic signed [DATA_W-1:0] v,
                            input bit given, input beat_t typed);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, v, op};
    do @(posedge clk); while (!s_axis_tready);
    predict_beat(op, v, !given);
    if (given) pending_beats.push_back(typed);
    @(negedge clk);
  endtask

  // hold the sender off until every predicted beat has come out
  task automatic drain_results;
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // extremes and tight clusters so ties show up often
  function automatic logic signed [DATA_W-1:0] rand_value;
    case ($urandom_range(9))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4, 5:    return $signed($urandom_range(7)) - 32'sd3;
      default: return $signed($urandom);
    endcase
  endfunction

  function automatic void note_mismatch(string what, beat_t want, beat_t got);
    failures++;
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch (%s): want value %0d status %0d last %0b,",
               $time, what, want.value, want.status, want.last,
               " got value %0d status %0d last %0b", got.value, got.status, got.last);
  endfunction

  // scoreboard: each master beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_beat.value  = m_axis_tdata[31:0];
      seen_beat.status = status_t'(m_axis_tdata[33:32]);
      seen_beat.last   = m_axis_tlast;
      beats_checked++;
      if (pending_beats.size() == 0) begin
        note_mismatch("unexpected beat", '0, seen_beat);
      end else begin
        want_beat = pending_beats.pop_front();
        if (seen_beat.value !== want_beat.value || seen_beat.status !== want_beat.status ||
            seen_beat.last !== want_beat.last)
          note_mismatch("result beat", want_beat, seen_beat);
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no beat moved for %0d cycles", $time, STALL_LIMIT);
      $display("max_heap_priority_queue regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    int sent;
    int run_len;
    int pick;
    bit filled;
    logic [1:0] rop;

    send_idle_pct = 12;
    recv_idle_pct = 86;
    held          = 0;
    failures      = 0;
    mismatches    = 0;
    beats_checked = 0;
    stall_cycles  = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows
    foreach (DIRECTED_ROWS[r])
      drive_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].given,
                 make_beat(DIRECTED_ROWS[r].want_value, DIRECTED_ROWS[r].want_status, 1'b1));
    drain_results();

    // three random runs: sender light / receiver heavy, swapped, then no idling
    for (int run = 0; run < 3; run++) begin
      case (run)
        0:       begin send_idle_pct = 12; recv_idle_pct = 86; end
        1:       begin send_idle_pct = 86; recv_idle_pct = 12; end
        default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
      endcase
      sent   = 0;
      filled = 1'b0;
      while (sent < RUN_ITEMS) begin
        if (!filled && sent >= RUN_ITEMS / 3) begin
          // fill to capacity, overflow a few times, then empty by sort or take some out by deletes
          while (held < CAPACITY) begin
            drive_beat(OP_INSERT, rand_value(), 1'b0, '0);
            sent++;
          end
          run_len = $urandom_range(1, 3);
          repeat (run_len) begin
            drive_beat(OP_INSERT, rand_value(), 1'b0, '0);
            sent++;
          end
          if ($urandom_range(1)) begin
            drive_beat(OP_SORT, rand_value(), 1'b0, '0);
            sent++;
          end else begin
            repeat ($urandom_range(3, 12)) begin
              drive_beat(OP_DELETE, rand_value(), 1'b0, '0);
              sent++;
            end
          end
          filled = 1'b1;
        end else begin
          pick = $urandom_range(99);
          if (pick < 45) begin
            run_len = $urandom_range(1, 8);
            repeat (run_len) begin
              drive_beat(OP_INSERT, rand_value(), 1'b0, '0);
              sent++;
            end
          end else if (pick < 70) begin
            run_len = $urandom_range(1, 6);
            repeat (run_len) begin
              drive_beat(OP_DELETE, $signed($urandom), 1'b0, '0);
              sent++;
            end
          end else if (pick < 80) begin
            drive_beat(OP_SORT, $signed($urandom), 1'b0, '0);
            sent++;
          end else if (pick < 88) begin
            // ignored code, not counted toward the run
            drive_beat(OP_NOP, $signed($urandom), 1'b0, '0);
          end else begin
            repeat ($urandom_range(1, 4)) begin
              rop = 2'($urandom_range(2));
              drive_beat(rop, rand_value(), 1'b0, '0);
              sent++;
            end
          end
        end
      end
      drain_results();
    end

    // let a trailing ignored beat or stray output show up
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0) begin
      failures++;
      $display("%0d predicted beats never came out", pending_beats.size());
    end

    $display("covered %0d inserts (%0d refused full), %0d deletes, %0d sorts (%0d empty ops)",
             n_insert, n_full, n_delete, n_sort, n_empty);
    $display("%0d values drained by sort, longest sort %0d, %0d beats checked, %0d mismatches",
             n_drained, max_sort, beats_checked, mismatches);
    if (failures == 0)
      $display("max_heap_priority_queue regression: pass");
    else
      $display("max_heap_priority_queue regression: fail");
    $finish;
  end

endmodule
